@@ rtl/core/grla_pkg.sv @@
package grla_pkg;

	localparam int MAX_GROUPS_DEF  = 8;
	localparam int MAX_WAITERS_DEF = 16;
	localparam int ID_WIDTH_DEF    = 16;

	localparam int FIELD_W = 16;
	localparam int HOLD_W  = 8;
	localparam logic [HOLD_W-1:0] HOLD_MAX = 8'd255;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;

	typedef enum logic [1:0] {
		OP_LOCK   = 2'd0,
		OP_TRY    = 2'd1,
		OP_UNLOCK = 2'd2,
		OP_BAD    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_GRANTED  = 3'd0,
		ST_QUEUED   = 3'd1,
		ST_REFUSED  = 3'd2,
		ST_HELD     = 3'd3,
		ST_RELEASED = 3'd4,
		ST_WOKEN    = 3'd5,
		ST_ERROR    = 3'd6
	} status_t;

	typedef struct packed {
		op_t                op;
		logic [FIELD_W-1:0] root;
		logic [FIELD_W-1:0] tag;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

@@ rtl/core/grla_front.sv @@
module grla_front #(
	parameter int ID_WIDTH = grla_pkg::ID_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   operation,
	input  logic [grla_pkg::FIELD_W-1:0] group_root,
	input  logic [grla_pkg::FIELD_W-1:0] task_tag,
	input  grla_pkg::q_stat_t            q_stat,
	output logic                         push,
	output grla_pkg::cmd_t               cmd
);
	import grla_pkg::*;

	localparam logic [FIELD_W-1:0] IdMask = (ID_WIDTH >= FIELD_W) ? {FIELD_W{1'b1}} :
		FIELD_W'((64'd1 << ID_WIDTH) - 64'd1);

	logic vld_s1;
	cmd_t cmd_s1;
	op_t  op_dec;

	always_comb begin
		case (operation)
			OP_LOCK:   op_dec = OP_LOCK;
			OP_TRY:    op_dec = OP_TRY;
			OP_UNLOCK: op_dec = OP_UNLOCK;
			default:   op_dec = OP_BAD;
		endcase
	end

	assign in_ready = !vld_s1 || !q_stat.full;
	assign push     = vld_s1 && !q_stat.full;
	assign cmd      = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1.op   <= op_dec;
			cmd_s1.root <= group_root & IdMask;
			cmd_s1.tag  <= task_tag & IdMask;
		end
	end

endmodule

@@ rtl/core/grla_queue.sv @@
module grla_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  grla_pkg::cmd_t    push_cmd,
	input  logic              pop,
	output grla_pkg::cmd_t    head_cmd,
	output grla_pkg::q_stat_t q_stat
);
	import grla_pkg::*;

	localparam int CntW = $clog2(QDEPTH + 1);

	cmd_t              slots_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [CntW-1:0]   count_q;

	assign q_stat.empty = (count_q == '0);
	assign q_stat.full  = (count_q == CntW'(QDEPTH));
	assign head_cmd     = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

@@ rtl/core/grla_back.sv @@
module grla_back #(
	parameter int MAX_GROUPS  = grla_pkg::MAX_GROUPS_DEF,
	parameter int MAX_WAITERS = grla_pkg::MAX_WAITERS_DEF,
	parameter int ID_WIDTH    = grla_pkg::ID_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  grla_pkg::q_stat_t            q_stat,
	input  grla_pkg::cmd_t               head_cmd,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [2:0]                   status,
	output logic [grla_pkg::FIELD_W-1:0] out_task,
	output logic [grla_pkg::FIELD_W-1:0] out_root,
	output logic                         last
);
	import grla_pkg::*;

	localparam int IdW   = (ID_WIDTH < FIELD_W) ? ID_WIDTH : FIELD_W;
	localparam int SlotW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int GCntW = $clog2(MAX_GROUPS + 1);
	localparam int WaitW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
	localparam int CntW  = $clog2(MAX_WAITERS + 1);
	localparam int MemD  = 2 ** (SlotW + WaitW);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_MATCH = 7'b0000010,
		S_EXEC  = 7'b0000100,
		S_HREAD = 7'b0001000,
		S_HREL  = 7'b0010000,
		S_WREAD = 7'b0100000,
		S_WEMIT = 7'b1000000
	} state_t;

	state_t state_q;
	cmd_t   cur_q;

	logic [IdW-1:0]    owner_root_q;
	logic              owner_vld_q;
	logic [HOLD_W-1:0] hold_q;
	logic [SlotW-1:0]  head_q;
	logic [GCntW-1:0]  gcnt_q;
	logic              slot_vld_q [MAX_GROUPS];
	logic [IdW-1:0]    roots_q    [MAX_GROUPS];
	logic [CntW-1:0]   wcnt_q     [MAX_GROUPS];

	logic             match_any_q;
	logic [SlotW-1:0] fslot_q;
	logic [CntW-1:0]  fcnt_q;
	logic [SlotW-1:0] hslot_q;
	logic [CntW-1:0]  hcnt_q;
	logic [CntW-1:0]  k_q;

	logic [2*IdW-1:0] mem [MemD];
	logic [2*IdW-1:0] rd_q;

	status_t          status_q;
	logic [IdW-1:0]   otask_q;
	logic [IdW-1:0]   oroot_q;
	logic             last_q;

	logic [IdW-1:0]   cur_root;
	logic [IdW-1:0]   cur_tag;
	logic [IdW-1:0]   rd_root;
	logic [IdW-1:0]   rd_tag;
	logic             m_any;
	logic [SlotW-1:0] m_slot;
	logic [CntW-1:0]  m_cnt;
	logic [CntW-1:0]  head_cnt;
	logic [GCntW:0]   slot_sum;
	logic [SlotW-1:0] new_slot;
	logic [SlotW-1:0] head_next;
	logic             out_free;
	logic             grantable;
	logic             wlast;

	logic             emit;
	status_t          e_st;
	logic [IdW-1:0]   e_task;
	logic [IdW-1:0]   e_root;
	logic             e_last;
	logic             act_grant;
	logic             act_q_old;
	logic             act_q_new;
	logic             act_held;
	logic             act_free;
	logic             act_hoff;

	assign cur_root  = cur_q.root[IdW-1:0];
	assign cur_tag   = cur_q.tag[IdW-1:0];
	assign rd_root   = rd_q[2*IdW-1:IdW];
	assign rd_tag    = rd_q[IdW-1:0];
	assign out_free  = !out_valid || out_ready;
	assign grantable = !owner_vld_q || (owner_root_q == cur_root);
	assign wlast     = (k_q + 1'b1) == hcnt_q;
	assign pop       = (state_q == S_IDLE) && !q_stat.empty;
	assign head_next = (head_q == SlotW'(MAX_GROUPS - 1)) ? '0 : head_q + 1'b1;

	always_comb begin
		slot_sum = (GCntW + 1)'(head_q) + (GCntW + 1)'(gcnt_q);
		if (slot_sum >= (GCntW + 1)'(MAX_GROUPS)) begin
			slot_sum = slot_sum - (GCntW + 1)'(MAX_GROUPS);
		end
		new_slot = slot_sum[SlotW-1:0];
	end

	always_comb begin
		m_any    = 1'b0;
		m_slot   = '0;
		m_cnt    = '0;
		head_cnt = '0;
		for (int i = 0; i < MAX_GROUPS; i++) begin
			if (slot_vld_q[i] && (roots_q[i] == cur_root)) begin
				m_any  = 1'b1;
				m_slot = m_slot | SlotW'(i);
				m_cnt  = m_cnt | wcnt_q[i];
			end
			if (SlotW'(i) == head_q) begin
				head_cnt = head_cnt | wcnt_q[i];
			end
		end
	end

	always_comb begin
		emit      = 1'b0;
		e_st      = ST_ERROR;
		e_task    = cur_tag;
		e_root    = cur_root;
		e_last    = 1'b1;
		act_grant = 1'b0;
		act_q_old = 1'b0;
		act_q_new = 1'b0;
		act_held  = 1'b0;
		act_free  = 1'b0;
		act_hoff  = 1'b0;
		case (state_q)
			S_EXEC: begin
				if (out_free) begin
					emit = 1'b1;
					case (cur_q.op)
						OP_LOCK, OP_TRY: begin
							if (grantable) begin
								if (hold_q != HOLD_MAX) begin
									act_grant = 1'b1;
									e_st      = ST_GRANTED;
								end
							end else if (cur_q.op == OP_TRY) begin
								e_st = ST_REFUSED;
							end else if (match_any_q) begin
								if (fcnt_q < CntW'(MAX_WAITERS)) begin
									act_q_old = 1'b1;
									e_st      = ST_QUEUED;
								end
							end else if (gcnt_q < GCntW'(MAX_GROUPS)) begin
								act_q_new = 1'b1;
								e_st      = ST_QUEUED;
							end
						end
						OP_UNLOCK: begin
							if (owner_vld_q && (hold_q != '0)) begin
								if (hold_q != HOLD_W'(1)) begin
									act_held = 1'b1;
									e_st     = ST_HELD;
									e_root   = owner_root_q;
								end else if (gcnt_q == '0) begin
									act_free = 1'b1;
									e_st     = ST_RELEASED;
									e_root   = '0;
								end else begin
									act_hoff = 1'b1;
									emit     = 1'b0;
								end
							end
						end
						default: begin
							e_st = ST_ERROR;
						end
					endcase
				end
			end
			S_HREL: begin
				if (out_free) begin
					emit   = 1'b1;
					e_st   = ST_RELEASED;
					e_root = rd_root;
					e_last = 1'b0;
				end
			end
			S_WEMIT: begin
				if (out_free) begin
					emit   = 1'b1;
					e_st   = ST_WOKEN;
					e_task = rd_tag;
					e_root = owner_root_q;
					e_last = wlast;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			owner_root_q <= '0;
			owner_vld_q  <= 1'b0;
			hold_q       <= '0;
			head_q       <= '0;
			gcnt_q       <= '0;
			out_valid    <= 1'b0;
			for (int i = 0; i < MAX_GROUPS; i++) begin
				slot_vld_q[i] <= 1'b0;
				wcnt_q[i]     <= '0;
			end
		end else begin
			if (emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (!q_stat.empty) begin
						state_q <= S_MATCH;
					end
				end
				S_MATCH: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (out_free) begin
						state_q <= act_hoff ? S_HREAD : S_IDLE;
					end
					if (act_grant) begin
						owner_root_q <= cur_root;
						owner_vld_q  <= 1'b1;
						hold_q       <= hold_q + 1'b1;
					end
					if (act_q_old) begin
						wcnt_q[fslot_q] <= fcnt_q + 1'b1;
					end
					if (act_q_new) begin
						slot_vld_q[new_slot] <= 1'b1;
						wcnt_q[new_slot]     <= CntW'(1);
						gcnt_q               <= gcnt_q + 1'b1;
					end
					if (act_held) begin
						hold_q <= hold_q - 1'b1;
					end
					if (act_free) begin
						hold_q       <= '0;
						owner_vld_q  <= 1'b0;
						owner_root_q <= '0;
					end
				end
				S_HREAD: begin
					state_q <= S_HREL;
				end
				S_HREL: begin
					if (out_free) begin
						owner_root_q        <= rd_root;
						owner_vld_q         <= 1'b1;
						hold_q              <= HOLD_W'(hcnt_q);
						head_q              <= head_next;
						gcnt_q              <= gcnt_q - 1'b1;
						slot_vld_q[hslot_q] <= 1'b0;
						wcnt_q[hslot_q]     <= '0;
						state_q             <= S_WREAD;
					end
				end
				S_WREAD: begin
					state_q <= S_WEMIT;
				end
				S_WEMIT: begin
					if (out_free) begin
						state_q <= wlast ? S_IDLE : S_WREAD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head_cmd;
		end
		if (state_q == S_MATCH) begin
			match_any_q <= m_any;
			fslot_q     <= m_slot;
			fcnt_q      <= m_cnt;
		end
		if (act_hoff) begin
			hslot_q <= head_q;
			hcnt_q  <= head_cnt;
			k_q     <= '0;
		end else if (state_q == S_WEMIT && out_free) begin
			k_q <= k_q + 1'b1;
		end
		if (act_q_new) begin
			roots_q[new_slot] <= cur_root;
		end
		if (emit) begin
			status_q <= e_st;
			otask_q  <= e_task;
			oroot_q  <= e_root;
			last_q   <= e_last;
		end
	end

	always_ff @(posedge clk) begin
		if (act_q_old) begin
			mem[{fslot_q, fcnt_q[WaitW-1:0]}] <= {cur_root, cur_tag};
		end else if (act_q_new) begin
			mem[{new_slot, WaitW'(0)}] <= {cur_root, cur_tag};
		end
		rd_q <= mem[{hslot_q, k_q[WaitW-1:0]}];
	end

	assign status   = status_q;
	assign out_task = FIELD_W'(otask_q);
	assign out_root = FIELD_W'(oroot_q);
	assign last     = last_q;

endmodule

@@ rtl/core/group_reentrant_lock_arbiter.sv @@
// Group-reentrant lock arbiter with FIFO hand-off between task groups.
// Input channel: in_valid/in_ready with operation (0 lock, 1 try lock,
// 2 unlock), group_root and task_tag. Output channel: out_valid/out_ready
// with status, out_task, out_root and last; last marks the final result
// of an item. An unlock that hands the lock to a waiting group gives one
// released result followed by one woken result per parked task.
// A front stage registers and decodes each item into a two-entry queue;
// the back end executes one item at a time against the lock state.
// The back end takes a single-result item through pop, group match and
// execute; a hand-off that wakes N tasks adds a read of the head group's
// waiter memory before the released result, then one more read per
// woken task, since each woken task needs one waiter memory read.
// The front keeps accepting while the queue has room.
// Reset clears the lock to free, empties the group FIFO and waiter counts
// and drops any queued or pending items; no clearing pass is needed.
// When the receiver stalls, the result holds in the output register, the
// back end waits, and the queue and then in_ready back up.
module group_reentrant_lock_arbiter #(
	parameter int MAX_GROUPS  = grla_pkg::MAX_GROUPS_DEF,
	parameter int MAX_WAITERS = grla_pkg::MAX_WAITERS_DEF,
	parameter int ID_WIDTH    = grla_pkg::ID_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   operation,
	input  logic [grla_pkg::FIELD_W-1:0] group_root,
	input  logic [grla_pkg::FIELD_W-1:0] task_tag,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [2:0]                   status,
	output logic [grla_pkg::FIELD_W-1:0] out_task,
	output logic [grla_pkg::FIELD_W-1:0] out_root,
	output logic                         last
);
	import grla_pkg::*;

	q_stat_t q_stat;
	cmd_t    push_cmd;
	cmd_t    head_cmd;
	logic    push;
	logic    pop;

	grla_front #(
		.ID_WIDTH(ID_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.group_root(group_root),
		.task_tag  (task_tag),
		.q_stat    (q_stat),
		.push      (push),
		.cmd       (push_cmd)
	);

	grla_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head_cmd(head_cmd),
		.q_stat  (q_stat)
	);

	grla_back #(
		.MAX_GROUPS (MAX_GROUPS),
		.MAX_WAITERS(MAX_WAITERS),
		.ID_WIDTH   (ID_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.head_cmd (head_cmd),
		.pop      (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.out_task (out_task),
		.out_root (out_root),
		.last     (last)
	);

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("queue popped while empty");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("queue pushed while full");

	a_multi_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> (status == ST_RELEASED || status == ST_WOKEN))
		else $error("non-final result outside a hand-off");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(status) &&
		$stable(out_task) && $stable(out_root) && $stable(last)))
		else $error("result changed while stalled");

endmodule
